[hw/rtl/binary_dilation_3x3_ring_unit_assert.svh]
// assertion macros for the binary dilation ring unit
`ifndef BINARY_DILATION_3X3_RING_UNIT_ASSERT_SVH
`define BINARY_DILATION_3X3_RING_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// clocked assertion, off while reset is high
`define BDR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked assertion, checked during reset too
`define BDR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`else

`define BDR_ASSERT(label, clk, rst, prop)
`define BDR_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[hw/rtl/bdr_pkg.sv]
// shared constants, types and window logic for the binary dilation ring unit
package bdr_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;

   localparam int CFG_W  = 10;
   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int PIX_W  = 8;
   localparam int IDX_W  = 2;

   localparam logic [PIX_W-1:0] WHITE_VALUE = 8'd255;
   localparam logic [PIX_W-1:0] BLACK_VALUE = 8'd0;

   localparam logic [IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [IDX_W-1:0] CSR_RING_MODE    = 2'd2;

   // line store word: bit 0 row above, bit 1 row two above
   localparam int LS_ABOVE = 0;
   localparam int LS_TWO   = 1;

   typedef struct packed {
      logic              eol;
      logic              eof;
      logic              mid;
      logic              w_one;
      logic              col_one;
      logic              bottom;
      logic              row_one;
      logic              black;
      logic [ADDR_W-1:0] col;
   } s1_ctrl_type;

   function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] maxv);
      logic [CFG_W-1:0] r;
      if (v == '0) begin
         r = CFG_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // column triple: bit 0 top, bit 1 middle, bit 2 bottom
   function automatic logic [PIX_W-1:0] dilate(input logic [2:0] left,
                                               input logic [2:0] centre,
                                               input logic [2:0] right,
                                               input logic       ring);
      logic any;
      any = (|left) | (|right) | centre[0] | centre[2];
      if (ring && centre[1] && any) begin
         any = 1'b0;
      end
      return any ? BLACK_VALUE : WHITE_VALUE;
   endfunction

endpackage

[hw/rtl/bdr_line_store.sv]
// two line stores of one bit each, kept as one two-bit wide ram
module bdr_line_store (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [bdr_pkg::ADDR_W-1:0] rd_addr,
   output logic [1:0]                rd_data,
   input  logic                      wr_en,
   input  logic [bdr_pkg::ADDR_W-1:0] wr_addr,
   input  logic [1:0]                wr_data
);
   import bdr_pkg::*;

   logic [1:0] line_mem_ff [MAX_WIDTH];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/binary_dilation_3x3_ring_unit.sv]
// top level of the streaming 3x3 binary dilation unit with ring mode
// Takes one word per clock while the output can advance and gives at most one result word
// per accepted word, with the result register loaded from the stage 1 register. The rate is
// set by the single line store ram, read once at acceptance and written once as the word
// leaves stage 1, with a bypass for a column written and read back to back. Results trail
// the input by frame_width+1 words; after the last pixel the host sends frame_width+1
// drain words (req_func = 1) to flush the frame, and rsp_out_last marks its final pixel.
// Configuration is taken on any cycle but should only be written while the unit is idle.
`include "binary_dilation_3x3_ring_unit_assert.svh"

module binary_dilation_3x3_ring_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_func,
   input  logic [bdr_pkg::PIX_W-1:0]  req_pixel,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [bdr_pkg::PIX_W-1:0]  rsp_out_pixel,
   output logic                       rsp_out_last,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [bdr_pkg::IDX_W-1:0]  csr_index,
   input  logic [bdr_pkg::CFG_W-1:0]  csr_data
);
   import bdr_pkg::*;

   logic [CFG_W-1:0] frame_width_ff;
   logic [CFG_W-1:0] frame_height_ff;
   logic             ring_mode_ff;

   logic [CFG_W-1:0] in_column_ff, in_column_in;
   logic [CFG_W-1:0] in_row_ff, in_row_in;

   logic             s1_valid_ff;
   s1_ctrl_type      s1_ff, s1_in;
   logic             fwd_ff, fwd_in;
   logic [1:0]       fwd_data_ff;

   logic [8:0]       window_ff, window_in;

   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_out_pixel_ff, rsp_out_pixel_in;
   logic             rsp_out_last_ff;
   logic             rsp_fire_in;

   logic             advance;
   logic             accept;

   logic [CFG_W-1:0] w_eff, h_eff;
   logic             wrap0, eol0, eof0;
   logic [CFG_W-1:0] col0, row0, col_inc;

   logic [1:0]       rd_data;
   logic             wr_en;
   logic [1:0]       wr_data;
   logic             above1, two1, two_eff, b1;
   logic [2:0]       triple, l_old, c_old, r_old;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= CFG_W'(MAX_WIDTH);
         frame_height_ff <= CFG_W'(MAX_HEIGHT);
         ring_mode_ff    <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            CSR_RING_MODE:    ring_mode_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign w_eff = clamp_size(frame_width_ff, CFG_W'(MAX_WIDTH));
   assign h_eff = clamp_size(frame_height_ff, CFG_W'(MAX_HEIGHT));

   // handshake
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   // position tracking at acceptance
   always_comb begin
      wrap0   = in_column_ff >= w_eff;
      col0    = wrap0 ? '0 : in_column_ff;
      row0    = wrap0 ? in_row_ff + CFG_W'(1) : in_row_ff;
      eol0    = (col0 == '0) && (row0 >= CFG_W'(2));
      eof0    = eol0 && ({1'b0, row0} >= ({1'b0, h_eff} + (CFG_W + 1)'(1)));
      col_inc = col0 + CFG_W'(1);

      in_column_in = in_column_ff;
      in_row_in    = in_row_ff;
      if (accept) begin
         priority if (eof0) begin
            in_column_in = '0;
            in_row_in    = '0;
         end else if (col_inc >= w_eff) begin
            in_column_in = '0;
            in_row_in    = row0 + CFG_W'(1);
         end else begin
            in_column_in = col_inc;
            in_row_in    = row0;
         end
      end

      s1_in.eol     = eol0;
      s1_in.eof     = eof0;
      s1_in.mid     = (col0 != '0) && (row0 != '0);
      s1_in.w_one   = w_eff == CFG_W'(1);
      s1_in.col_one = col0 == CFG_W'(1);
      s1_in.bottom  = row0 >= h_eff;
      s1_in.row_one = row0 == CFG_W'(1);
      s1_in.black   = !req_func && (req_pixel == '0);
      s1_in.col     = col0[ADDR_W-1:0];

      fwd_in = s1_valid_ff && !s1_ff.eof && (s1_ff.col == col0[ADDR_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff <= '0;
         in_row_ff    <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         in_column_ff <= in_column_in;
         in_row_ff    <= in_row_in;
         if (advance) begin
            s1_valid_ff <= accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff       <= s1_in;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= wr_data;
      end
   end

   bdr_line_store u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col0[ADDR_W-1:0]),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (s1_ff.col),
      .wr_data (wr_data)
   );

   // window and result
   always_comb begin
      above1  = fwd_ff ? fwd_data_ff[LS_ABOVE] : rd_data[LS_ABOVE];
      two1    = fwd_ff ? fwd_data_ff[LS_TWO] : rd_data[LS_TWO];
      b1      = s1_ff.bottom ? above1 : s1_ff.black;
      two_eff = s1_ff.row_one ? above1 : two1;
      triple  = {b1, above1, two_eff};

      wr_en                = s1_valid_ff && !s1_ff.eof && advance;
      wr_data[LS_ABOVE]    = b1;
      wr_data[LS_TWO]      = above1;

      l_old = window_ff[2:0];
      c_old = window_ff[5:3];
      r_old = window_ff[8:6];

      window_in        = window_ff;
      rsp_fire_in      = 1'b0;
      rsp_out_pixel_in = rsp_out_pixel_ff;
      if (s1_valid_ff) begin
         if (s1_ff.eof) begin
            window_in = '0;
         end else begin
            window_in = {triple, r_old, c_old};
         end
         if (s1_ff.eol) begin
            rsp_fire_in      = 1'b1;
            rsp_out_pixel_in = dilate(s1_ff.w_one ? r_old : c_old, r_old, r_old,
                                      ring_mode_ff);
         end else if (s1_ff.mid) begin
            rsp_fire_in      = 1'b1;
            rsp_out_pixel_in = dilate(s1_ff.col_one ? r_old : c_old, r_old, triple,
                                      ring_mode_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_fire_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && rsp_fire_in) begin
         rsp_out_pixel_ff <= rsp_out_pixel_in;
         rsp_out_last_ff  <= s1_ff.eof;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pixel = rsp_out_pixel_ff;
   assign rsp_out_last  = rsp_out_last_ff;

   // checks
   `BDR_ASSERT(a_pixel_binary, clock, reset,
      rsp_valid_ff |-> (rsp_out_pixel_ff == BLACK_VALUE || rsp_out_pixel_ff == WHITE_VALUE))
   `BDR_ASSERT(a_column_in_range, clock, reset,
      in_column_ff < CFG_W'(MAX_WIDTH))
   `BDR_ASSERT(a_frame_end_clears, clock, reset,
      (s1_valid_ff && s1_ff.eof && advance) |=> (window_ff == '0))
   `BDR_ASSERT(a_frame_end_position, clock, reset,
      (accept && eof0) |=> (in_column_ff == '0 && in_row_ff == '0))
   `BDR_ASSERT_ALWAYS(a_no_result_in_reset, clock,
      reset |=> !rsp_valid_ff)

endmodule
